/* sv/sbtc_pkg.sv */
// Shared widths, register indexes and helper constants for the braking tilt controller.
package sbtc_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int VEL_W   = 21;
    localparam int TILT_W  = 12;
    localparam int ANGLE_W = 11;
    localparam int GAIN_W  = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Shared divider: dividend width, divisor width, step counter width
    localparam int DIV_W   = 24;
    localparam int DEN_W   = 16;
    localparam int CNT_W   = 5;

    // Square root: radicand width and iteration count
    localparam int RAD_W     = 32;
    localparam int SQRT_ITER = 16;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_EDGE_GUARD     = 3'd0;
    localparam logic [IDX_W-1:0] REG_EDGE_TILT      = 3'd1;
    localparam logic [IDX_W-1:0] REG_PIPE_LENGTH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_BRAKE_ACCEL    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEED_LIMIT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_VELOCITY_GAIN  = 3'd5;
    localparam logic [IDX_W-1:0] REG_ACCEL_PER_STEP = 3'd6;
    localparam logic [IDX_W-1:0] REG_TILT_LIMIT     = 3'd7;

    // Square root starting bit
    localparam logic [RAD_W-1:0] SQRT_TOP_BIT = 32'h4000_0000;

    typedef logic [POS_W-1:0] pos_t;

endpackage

/* sv/sqrt_braking_tilt_controller.sv */
// Square-root braking tilt controller: sequencer around one shared sqrt/divide datapath.
// Sequence: S_IDLE accepts, S_CHECK sends an edge zone straight to S_OUT; else S_SQRT runs
// 16 square-root steps, S_LDIV one 24-step restoring division, then S_REF and S_ACC; a zero
// divisor goes to S_OUT, else S_TDIV runs a second 24-step division on the shared divider and
// then S_FIN. Requests are taken only in S_IDLE; a result that still waits at the output register holds the next one.
// Reset: asynchronous active-low; clears sequencer and output valid, loads register defaults.
module sqrt_braking_tilt_controller
    import sbtc_pkg::*;
#(
    parameter int DIST_GAIN_NUM = 4,
    parameter int DIST_GAIN_DEN = 1,
    parameter int ACCEL_LIMIT   = 50000
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [POS_W-1:0]          setpoint,
    input  logic [POS_W-1:0]          ball_position,
    input  logic signed [VEL_W-1:0]   ball_velocity,
    input  logic signed [VEL_W-1:0]   integral_term,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [TILT_W-1:0]  tilt_command
);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_LDIV  = 4'd3;
    localparam logic [3:0] S_REF   = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_TDIV  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [DIV_W-1:0]       LIN_GAIN = DIV_W'(DIST_GAIN_NUM);
    localparam logic [DEN_W-1:0]       LIN_DEN  = DEN_W'(DIST_GAIN_DEN);
    localparam logic signed [30:0]     ACC_LIM  = 31'(ACCEL_LIMIT);
    localparam logic [CNT_W-1:0]       SQRT_LAST = CNT_W'(SQRT_ITER - 1);
    localparam logic [CNT_W-1:0]       DIV_LAST  = CNT_W'(DIV_W - 1);

    // Configuration registers
    logic [CFG_W-1:0]   edge_guard_reg;
    logic [ANGLE_W-1:0] edge_tilt_reg;
    logic [CFG_W-1:0]   pipe_length_reg;
    logic [CFG_W-1:0]   brake_accel_reg;
    logic [CFG_W-1:0]   speed_limit_reg;
    logic [GAIN_W-1:0]  velocity_gain_reg;
    logic [CFG_W-1:0]   accel_per_step_reg;
    logic [ANGLE_W-1:0] tilt_limit_reg;

    // Control registers
    logic [3:0]       state_reg,     state_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    pos_t                     tgt_reg,   tgt_next;
    pos_t                     pos_reg,   pos_next;
    logic signed [VEL_W-1:0]  vel_reg,   vel_next;
    logic signed [VEL_W-1:0]  integ_reg, integ_next;
    logic                     neg_reg,   neg_next;
    logic [RAD_W-1:0]         sq_v_reg,   sq_v_next;
    logic [RAD_W-1:0]         sq_res_reg, sq_res_next;
    logic [RAD_W-1:0]         sq_bit_reg, sq_bit_next;
    logic [DIV_W-1:0]         div_q_reg, div_q_next;
    logic [DEN_W-1:0]         div_r_reg, div_r_next;
    logic [POS_W-1:0]         brake_reg, brake_next;
    logic signed [21:0]       diff_reg,  diff_next;
    logic signed [TILT_W-1:0] res_reg,   res_next;
    logic signed [TILT_W-1:0] tilt_reg,  tilt_next;

    // Datapath intermediates
    logic signed [16:0]   far_bound;
    logic signed [16:0]   err;
    logic [POS_W-1:0]     abs_err;
    logic [RAD_W-1:0]     rad_prod;
    logic [RAD_W:0]       rad_dbl;
    logic [RAD_W:0]       sq_sum;
    logic [DEN_W-1:0]     div_den;
    logic [DEN_W:0]       div_sh;
    logic                 div_ge;
    logic [POS_W-1:0]     brake_cap;
    logic [POS_W-1:0]     ref_mag;
    logic signed [16:0]   ref_s;
    logic signed [30:0]   acc_prod;
    logic signed [30:0]   acc_sum;
    logic signed [30:0]   acc_clip;
    logic [30:0]          acc_mag;
    logic [ANGLE_W-1:0]   tilt_mag;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign tilt_command = tilt_reg;

    // Edge-zone bound and position error
    assign far_bound = $signed({1'b0, pipe_length_reg}) - $signed({1'b0, edge_guard_reg});
    assign err       = $signed({1'b0, tgt_reg}) - $signed({1'b0, pos_reg});
    assign abs_err   = err[16] ? POS_W'(-err) : err[POS_W-1:0];

    // Braking radicand, saturated to 32 bits
    assign rad_prod = brake_accel_reg * abs_err;
    assign rad_dbl  = {rad_prod, 1'b0};

    // Shared square-root step
    assign sq_sum = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};

    // Shared restoring divider step
    assign div_den = (state_reg == S_LDIV) ? LIN_DEN : accel_per_step_reg;
    assign div_sh  = {div_r_reg, div_q_reg[DIV_W-1]};
    assign div_ge  = (div_sh >= {1'b0, div_den});

    // Reference speed: braking speed capped, then the smaller of it and the linear speed
    assign brake_cap = (brake_reg > speed_limit_reg) ? speed_limit_reg : brake_reg;
    assign ref_mag   = (div_q_reg < DIV_W'(brake_cap)) ? div_q_reg[POS_W-1:0] : brake_cap;
    assign ref_s     = neg_reg ? -$signed({1'b0, ref_mag}) : $signed({1'b0, ref_mag});

    // Acceleration and clamp
    assign acc_prod = 31'($signed({1'b0, velocity_gain_reg}) * diff_reg);
    assign acc_sum  = acc_prod + 31'(integ_reg);
    always_comb
    begin
        if (acc_sum > ACC_LIM)
            acc_clip = ACC_LIM;
        else if (acc_sum < -ACC_LIM)
            acc_clip = -ACC_LIM;
        else
            acc_clip = acc_sum;
    end
    assign acc_mag = acc_clip[30] ? 31'(-acc_clip) : 31'(acc_clip);

    // Tilt magnitude limit
    assign tilt_mag = (div_q_reg > DIV_W'(tilt_limit_reg)) ? tilt_limit_reg
                                                           : div_q_reg[ANGLE_W-1:0];

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        tgt_next       = tgt_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        integ_next     = integ_reg;
        neg_next       = neg_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        brake_next     = brake_reg;
        diff_next      = diff_reg;
        res_next       = res_reg;
        tilt_next      = tilt_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a new request
                if (in_valid)
                begin
                    tgt_next   = setpoint;
                    pos_next   = ball_position;
                    vel_next   = ball_velocity;
                    integ_next = integral_term;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // Edge zones first, else load the square root and the linear dividend
                if (pos_reg <= edge_guard_reg)
                begin
                    res_next   = $signed({1'b0, edge_tilt_reg});
                    state_next = S_OUT;
                end
                else if ($signed({1'b0, pos_reg}) >= far_bound)
                begin
                    res_next   = -$signed({1'b0, edge_tilt_reg});
                    state_next = S_OUT;
                end
                else
                begin
                    neg_next    = err[16];
                    sq_v_next   = rad_dbl[RAD_W] ? '1 : rad_dbl[RAD_W-1:0];
                    sq_res_next = '0;
                    sq_bit_next = SQRT_TOP_BIT;
                    div_q_next  = DIV_W'(abs_err) * LIN_GAIN;
                    div_r_next  = '0;
                    cnt_next    = '0;
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // One square-root digit per cycle
                if ({1'b0, sq_v_reg} >= sq_sum)
                begin
                    sq_v_next   = sq_v_reg - sq_sum[RAD_W-1:0];
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_LDIV;
                end
            end
            S_LDIV, S_TDIV:
            begin
                // One quotient bit per cycle on the shared divider
                div_r_next = div_ge ? DEN_W'(div_sh - {1'b0, div_den}) : div_sh[DEN_W-1:0];
                div_q_next = {div_q_reg[DIV_W-2:0], div_ge};
                cnt_next   = cnt_reg + 1'b1;
                if (state_reg == S_LDIV)
                    brake_next = sq_res_reg[POS_W-1:0];
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_LDIV) ? S_REF : S_FIN;
                end
            end
            S_REF:
            begin
                // Velocity error against the signed reference speed
                diff_next  = 22'(ref_s) - 22'(vel_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // Clamp acceleration and load the rounded tilt division; a zero divisor yields a zero tilt
                neg_next   = acc_clip[30];
                div_q_next = DIV_W'(acc_mag) + DIV_W'(accel_per_step_reg >> 1);
                div_r_next = '0;
                cnt_next   = '0;
                if (accel_per_step_reg == '0)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_TDIV;
                end
            end
            S_FIN:
            begin
                // Limit and sign the tilt
                res_next   = neg_reg ? -$signed({1'b0, tilt_mag}) : $signed({1'b0, tilt_mag});
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    tilt_next      = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
            edge_guard_reg     <= 16'd200;
            edge_tilt_reg      <= 11'd50;
            pipe_length_reg    <= 16'd4000;
            brake_accel_reg    <= 16'd2000;
            speed_limit_reg    <= 16'd3000;
            velocity_gain_reg  <= 8'd4;
            accel_per_step_reg <= 16'd171;
            tilt_limit_reg     <= 11'd100;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_EDGE_GUARD:     edge_guard_reg     <= cfg_data;
                    REG_EDGE_TILT:      edge_tilt_reg      <= cfg_data[ANGLE_W-1:0];
                    REG_PIPE_LENGTH:    pipe_length_reg    <= cfg_data;
                    REG_BRAKE_ACCEL:    brake_accel_reg    <= cfg_data;
                    REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data;
                    REG_VELOCITY_GAIN:  velocity_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_ACCEL_PER_STEP: accel_per_step_reg <= cfg_data;
                    REG_TILT_LIMIT:     tilt_limit_reg     <= cfg_data[ANGLE_W-1:0];
                    default:            edge_guard_reg     <= edge_guard_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        tgt_reg    <= tgt_next;
        pos_reg    <= pos_next;
        vel_reg    <= vel_next;
        integ_reg  <= integ_next;
        neg_reg    <= neg_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        div_q_reg  <= div_q_next;
        div_r_reg  <= div_r_next;
        brake_reg  <= brake_next;
        diff_reg   <= diff_next;
        res_reg    <= res_next;
        tilt_reg   <= tilt_next;
    end

endmodule

/* test/tb_sqrt_braking_tilt_controller.sv */
// Self-checking testbench for the braking tilt controller: directed and random requests.
module tb_sqrt_braking_tilt_controller;
    import sbtc_pkg::*;

    localparam int DIST_NUM   = 4;
    localparam int DIST_DEN   = 1;
    localparam int ACCEL_CAP  = 50000;
    localparam int CYCLE_CAP  = 1000000;
    localparam int TAIL_WAIT  = 90;
    localparam longint RAD_MAX = 64'h0000_0000_FFFF_FFFF;

    // Hold the register copy, predict each tilt and compare against the block
    class tilt_scoreboard;
        longint reg_val[8];
        logic signed [TILT_W-1:0] expected_tilts[$];
        int errors;

        function new();
            errors = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            reg_val[REG_EDGE_GUARD]     = 200;
            reg_val[REG_EDGE_TILT]      = 50;
            reg_val[REG_PIPE_LENGTH]    = 4000;
            reg_val[REG_BRAKE_ACCEL]    = 2000;
            reg_val[REG_SPEED_LIMIT]    = 3000;
            reg_val[REG_VELOCITY_GAIN]  = 4;
            reg_val[REG_ACCEL_PER_STEP] = 171;
            reg_val[REG_TILT_LIMIT]     = 100;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_EDGE_TILT, REG_TILT_LIMIT: reg_val[idx] = value[ANGLE_W-1:0];
                REG_VELOCITY_GAIN:             reg_val[idx] = value[GAIN_W-1:0];
                default:                       reg_val[idx] = value;
            endcase
        endfunction

        // Largest r with r*r <= v, built one bit at a time from the top
        function longint floor_root(longint v);
            longint r = 0;
            longint t;
            for (int b = 15; b >= 0; b--)
            begin
                t = r | (longint'(1) << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function logic signed [TILT_W-1:0] predict_tilt(pos_t tgt, pos_t pos,
                logic signed [VEL_W-1:0] vel, logic signed [VEL_W-1:0] integ);
            longint p = pos;
            longint err, mag, rad, braking, vref, lin, acc, den, q;
            // Edge zones win over everything; the near end is tested first
            if (p <= reg_val[REG_EDGE_GUARD])
                return TILT_W'(reg_val[REG_EDGE_TILT]);
            if (p >= reg_val[REG_PIPE_LENGTH] - reg_val[REG_EDGE_GUARD])
                return TILT_W'(-reg_val[REG_EDGE_TILT]);

            err = longint'(tgt) - p;
            mag = (err < 0) ? -err : err;
            rad = 2 * reg_val[REG_BRAKE_ACCEL] * mag;
            if (rad > RAD_MAX)
                rad = RAD_MAX;
            braking = floor_root(rad);
            lin = mag * DIST_NUM / DIST_DEN;

            vref = (braking > reg_val[REG_SPEED_LIMIT]) ? reg_val[REG_SPEED_LIMIT] : braking;
            if (lin < vref)
                vref = lin;
            if (err < 0)
                vref = -vref;

            acc = reg_val[REG_VELOCITY_GAIN] * (vref - vel) + integ;
            if (acc > ACCEL_CAP)
                acc = ACCEL_CAP;
            if (acc < -ACCEL_CAP)
                acc = -ACCEL_CAP;

            // Round half away from zero; a zero divisor yields zero
            den = reg_val[REG_ACCEL_PER_STEP];
            if (den == 0)
                q = 0;
            else
            begin
                q = (((acc < 0) ? -acc : acc) + den / 2) / den;
                if (acc < 0)
                    q = -q;
            end
            if (q > reg_val[REG_TILT_LIMIT])
                q = reg_val[REG_TILT_LIMIT];
            if (q < -reg_val[REG_TILT_LIMIT])
                q = -reg_val[REG_TILT_LIMIT];
            return TILT_W'(q);
        endfunction

        function void note_request(pos_t tgt, pos_t pos,
                logic signed [VEL_W-1:0] vel, logic signed [VEL_W-1:0] integ);
            expected_tilts.push_back(predict_tilt(tgt, pos, vel, integ));
        endfunction

        function void check_tilt(logic signed [TILT_W-1:0] actual);
            logic signed [TILT_W-1:0] exp_tilt;
            if (expected_tilts.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected tilt_command %0d with no request pending", actual);
                errors++;
                return;
            end
            exp_tilt = expected_tilts.pop_front();
            if (actual !== exp_tilt)
            begin
                if (errors < 10)
                    $display("tilt_command mismatch: expected %0d, got %0d", exp_tilt, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_tilts.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    pos_t                     setpoint = '0;
    pos_t                     ball_position = '0;
    logic signed [VEL_W-1:0]  ball_velocity = '0;
    logic signed [VEL_W-1:0]  integral_term = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [TILT_W-1:0] tilt_command;

    tilt_scoreboard sb;
    bit  calm = 1'b0;
    int  in_gap_pct = 0;
    int  stall_pct = 0;
    int  stall_left = 0;
    int  cycle_count = 0;

    sqrt_braking_tilt_controller #(
        .DIST_GAIN_NUM (DIST_NUM),
        .DIST_GAIN_DEN (DIST_DEN),
        .ACCEL_LIMIT   (ACCEL_CAP)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .setpoint        (setpoint),
        .ball_position   (ball_position),
        .ball_velocity   (ball_velocity),
        .integral_term   (integral_term),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tilt_command    (tilt_command)
    );

    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 12);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Check every result taken from the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_tilt(tilt_command);
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic load_settings(int eg, int et, int pl, int ba, int sl, int vg, int aps,
            int tl);
        write_reg(REG_EDGE_GUARD, CFG_W'(eg));
        write_reg(REG_EDGE_TILT, CFG_W'(et));
        write_reg(REG_PIPE_LENGTH, CFG_W'(pl));
        write_reg(REG_BRAKE_ACCEL, CFG_W'(ba));
        write_reg(REG_SPEED_LIMIT, CFG_W'(sl));
        write_reg(REG_VELOCITY_GAIN, CFG_W'(vg));
        write_reg(REG_ACCEL_PER_STEP, CFG_W'(aps));
        write_reg(REG_TILT_LIMIT, CFG_W'(tl));
        cfg_write <= 1'b0;
        @(posedge clk);
        in_gap_pct = $urandom_range(0, 2) * 30;
        stall_pct  = $urandom_range(0, 2) * 30;
    endtask

    // Drop valid and wait until every expected tilt has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one request, holding it until the block takes it
    task automatic send_request(pos_t tgt, pos_t pos, logic signed [VEL_W-1:0] vel,
            logic signed [VEL_W-1:0] integ);
        if (!calm && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        setpoint      <= tgt;
        ball_position <= pos;
        ball_velocity <= vel;
        integral_term <= integ;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(tgt, pos, vel, integ);
    endtask

    // Mostly interior positions with random content, some edge boundaries and noise
    task automatic send_random_item();
        longint lo, hi;
        int pick;
        pos_t tgt, pos;
        logic signed [VEL_W-1:0] vel, integ;
        lo = sb.reg_val[REG_EDGE_GUARD] + 1;
        hi = sb.reg_val[REG_PIPE_LENGTH] - sb.reg_val[REG_EDGE_GUARD] - 1;
        pick = $urandom_range(0, 99);
        if (pick < 70 && lo <= hi)
            pos = POS_W'($urandom_range(int'(lo), int'(hi)));
        else if (pick < 85)
            case ($urandom_range(0, 3))
                0: pos = POS_W'(lo - 1);
                1: pos = POS_W'(lo);
                2: pos = POS_W'(hi);
                default: pos = POS_W'(hi + 1);
            endcase
        else
            pos = POS_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            tgt = pos + POS_W'($urandom_range(0, 4000)) - POS_W'(2000);
        else
            tgt = POS_W'($urandom);
        if ($urandom_range(0, 99) < 40)
            vel = VEL_W'($urandom_range(0, 8000)) - VEL_W'(4000);
        else
            vel = VEL_W'($urandom);
        if ($urandom_range(0, 99) < 40)
            integ = VEL_W'($urandom_range(0, 20000)) - VEL_W'(10000);
        else
            integ = VEL_W'($urandom);
        send_request(tgt, pos, vel, integ);
    endtask

    task automatic send_random_items(int count);
        repeat (count) send_random_item();
    endtask

    initial
    begin
        int eg;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: edge zones, boundaries, field extremes and rounding
        send_request(0, 0, 0, 0);
        send_request(65535, 200, 0, 0);
        send_request(2000, 201, 0, 0);
        send_request(2000, 3799, 0, 0);
        send_request(2000, 3800, 0, 0);
        send_request(0, 65535, -1048576, -1048576);
        send_request(65535, 1000, 1048575, 1048575);
        send_request(0, 3000, -1048576, 1048575);
        send_request(1500, 1500, 0, 85);
        send_request(1500, 1500, 0, 86);
        send_request(1500, 1500, 0, -85);
        send_request(1500, 1500, 0, -86);
        send_request(1500, 1500, 25, 0);
        send_request(1501, 1500, 0, 0);
        send_request(1000, 1500, 0, 0);
        send_request(3000, 1000, 0, 0);
        send_request(3700, 300, 0, 0);
        send_request(1500, 1500, -12000, 0);
        drain();

        // Upper extremes: radicand saturation and widest tilt
        load_settings(0, 1800, 65535, 65535, 65535, 255, 1, 1800);
        send_request(65535, 1, 0, 0);
        send_request(0, 65534, 0, 0);
        send_request(65535, 1, -1048576, 1048575);
        send_random_items(40);
        drain();

        // Lower extremes, including a zero divisor
        load_settings(0, 0, 65535, 0, 0, 0, 0, 0);
        send_random_items(25);
        drain();

        // Even divisor so that exact halves round away from zero
        load_settings(200, 50, 4000, 2000, 3000, 1, 2, 1800);
        send_request(1500, 1500, 0, 3);
        send_request(1500, 1500, 0, -3);
        send_request(1500, 1500, 0, 1);
        send_request(1500, 1500, 0, -1);
        send_random_items(25);
        drain();

        // Guard wider than the pipe: the far bound goes negative
        load_settings(300, 1800, 100, 2000, 3000, 4, 171, 100);
        send_random_items(15);
        drain();

        // Guard at its maximum: every position sits in the near zone
        load_settings(65535, 1234, 4000, 2000, 3000, 4, 171, 100);
        send_random_items(10);
        drain();

        // Random settings
        repeat (6)
        begin
            eg = $urandom_range(0, 3000);
            load_settings(eg, $urandom_range(0, 1800), $urandom_range(2 * eg + 50, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
                ($urandom_range(0, 1) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 65535),
                $urandom_range(0, 1800));
            send_random_items(40);
            drain();
        end

        // Closing stretch at full rate on both sides
        load_settings(200, 50, 4000, 2000, 3000, 4, 171, 100);
        calm = 1'b1;
        send_random_items(60);
        drain();

        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
